// ===== rtl/tvg_pkg.sv =====
// Types, constants and arithmetic helpers for the trilinear value/gradient core.
// Used by trilinear_value_and_gradient_core; depends on nothing.
package tvg_pkg;

  localparam int VALUE_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int SIZE_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int LERP_W    = VALUE_W + 2;
  localparam int DIV_W     = VALUE_W + 1 + FRAC_BITS;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAC_X = 3'd0,
    CFG_FRAC_Y = 3'd1,
    CFG_FRAC_Z = 3'd2,
    CFG_SIZE_X = 3'd3,
    CFG_SIZE_Y = 3'd4,
    CFG_SIZE_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] corner_000;
    logic signed [VALUE_W-1:0] corner_100;
    logic signed [VALUE_W-1:0] corner_010;
    logic signed [VALUE_W-1:0] corner_001;
    logic signed [VALUE_W-1:0] corner_101;
    logic signed [VALUE_W-1:0] corner_011;
    logic signed [VALUE_W-1:0] corner_110;
    logic signed [VALUE_W-1:0] corner_111;
  } corners_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] interp_value;
    logic signed [VALUE_W-1:0] grad_x;
    logic signed [VALUE_W-1:0] grad_y;
    logic signed [VALUE_W-1:0] grad_z;
    logic                      overflow;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rem;
    logic [DIV_W-1:0]  num;
  } div_t;

  // a + floor((b - a) * f / 2^FRAC_BITS)
  function automatic logic signed [LERP_W-1:0] lerp(input logic signed [LERP_W-1:0] a,
                                                    input logic signed [LERP_W-1:0] b,
                                                    input logic [FRAC_W-1:0] f);
    logic signed [LERP_W:0]          diff;
    logic signed [LERP_W+FRAC_W+1:0] prod;
    diff = (LERP_W+1)'(b) - (LERP_W+1)'(a);
    prod = diff * $signed({1'b0, f});
    return LERP_W'(a + LERP_W'(prod >>> FRAC_BITS));
  endfunction

  function automatic logic signed [LERP_W-1:0] ext(input logic signed [VALUE_W-1:0] v);
    return LERP_W'(v);
  endfunction

  // one restoring division step: quotient bits shift in at the bottom of num
  function automatic div_t div_step(input div_t s, input logic [SIZE_W-1:0] d);
    logic [SIZE_W:0] trial;
    logic            qbit;
    div_t            r;
    trial = {s.rem, s.num[DIV_W-1]};
    qbit  = (trial >= {1'b0, d});
    if (qbit) begin
      trial = trial - {1'b0, d};
    end
    r.rem = trial[SIZE_W-1:0];
    r.num = {s.num[DIV_W-2:0], qbit};
    return r;
  endfunction

endpackage

// ===== rtl/trilinear_value_and_gradient_core.sv =====
// Trilinear value and gradient core: lerp stages, pipelined dividers, saturation.
// Depends on tvg_pkg.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------
//  in      | in_valid_i   | in_stall_o   | in_data_i  (corners_t)
//  out     | out_valid_o  | out_stall_i  | out_data_o (result_t)
//  cfg     | cfg_we_i     | -            | cfg_idx_i, cfg_data_i
//
// One transaction per cycle while a valid output is not stalled; the pipeline depth is set by the
// one-bit-per-stage restoring dividers (three in parallel, one per axis).
// Reset clears the valid bits and loads the register defaults.
// A stall on a valid output freezes the whole pipeline; in_stall_o follows it.
module trilinear_value_and_gradient_core
  import tvg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SIZE_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  corners_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output result_t               out_data_o
);

  logic [FRAC_W-1:0] frac_q [3];
  logic [SIZE_W-1:0] size_q [3];
  logic [FRAC_W-1:0] fx, fy, fz;
  logic [SIZE_W-1:0] dsz [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        frac_q[i] <= '0;
        size_q[i] <= SIZE_W'(65536);
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAC_X: frac_q[0] <= cfg_data_i[FRAC_W-1:0];
        CFG_FRAC_Y: frac_q[1] <= cfg_data_i[FRAC_W-1:0];
        CFG_FRAC_Z: frac_q[2] <= cfg_data_i[FRAC_W-1:0];
        CFG_SIZE_X: size_q[0] <= cfg_data_i;
        CFG_SIZE_Y: size_q[1] <= cfg_data_i;
        CFG_SIZE_Z: size_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign fx = (frac_q[0] > FRAC_ONE) ? FRAC_ONE : frac_q[0];
  assign fy = (frac_q[1] > FRAC_ONE) ? FRAC_ONE : frac_q[1];
  assign fz = (frac_q[2] > FRAC_ONE) ? FRAC_ONE : frac_q[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsz[i] = (size_q[i] == '0) ? SIZE_W'(1) : size_q[i];
    end
  end

  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;

  // stage 1: first lerp level
  logic v1_q;
  logic signed [LERP_W-1:0] a00_q, a10_q, a01_q, a11_q;
  logic signed [LERP_W-1:0] gx0_q, gx1_q, gy0_q, gy1_q, gz0_q, gz1_q;
  // stage 2: second lerp level
  logic v2_q;
  logic signed [LERP_W-1:0] b0_q, b1_q, gx_q, gy_q, gz_q;
  // division pipeline, index 0 is loaded from stage 2
  logic              vd_q  [DIV_W+1];
  logic signed [VALUE_W-1:0] val_q [DIV_W+1];
  div_t              dv_q  [3][DIV_W+1];
  logic              neg_q [3][DIV_W+1];

  corners_t c;
  assign c = in_data_i;

  logic signed [LERP_W-1:0] g2 [3];
  logic signed [LERP_W-1:0] gmag [3];
  assign g2[0] = gx_q;
  assign g2[1] = gy_q;
  assign g2[2] = gz_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gmag[i] = g2[i][LERP_W-1] ? -g2[i] : g2[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int s = 0; s <= DIV_W; s++) begin
        vd_q[s] <= 1'b0;
      end
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      vd_q[0] <= v2_q;
      for (int s = 1; s <= DIV_W; s++) begin
        vd_q[s] <= vd_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a00_q <= lerp(ext(c.corner_000), ext(c.corner_100), fx);
      a10_q <= lerp(ext(c.corner_010), ext(c.corner_110), fx);
      a01_q <= lerp(ext(c.corner_001), ext(c.corner_101), fx);
      a11_q <= lerp(ext(c.corner_011), ext(c.corner_111), fx);
      gx0_q <= lerp(ext(c.corner_100) - ext(c.corner_000),
                    ext(c.corner_110) - ext(c.corner_010), fy);
      gx1_q <= lerp(ext(c.corner_101) - ext(c.corner_001),
                    ext(c.corner_111) - ext(c.corner_011), fy);
      gy0_q <= lerp(ext(c.corner_010) - ext(c.corner_000),
                    ext(c.corner_110) - ext(c.corner_100), fx);
      gy1_q <= lerp(ext(c.corner_011) - ext(c.corner_001),
                    ext(c.corner_111) - ext(c.corner_101), fx);
      gz0_q <= lerp(ext(c.corner_001) - ext(c.corner_000),
                    ext(c.corner_101) - ext(c.corner_100), fx);
      gz1_q <= lerp(ext(c.corner_011) - ext(c.corner_010),
                    ext(c.corner_111) - ext(c.corner_110), fx);

      b0_q <= lerp(a00_q, a10_q, fy);
      b1_q <= lerp(a01_q, a11_q, fy);
      gx_q <= lerp(gx0_q, gx1_q, fz);
      gy_q <= lerp(gy0_q, gy1_q, fz);
      gz_q <= lerp(gz0_q, gz1_q, fy);

      val_q[0] <= VALUE_W'(lerp(b0_q, b1_q, fz));
      for (int i = 0; i < 3; i++) begin
        dv_q[i][0].rem <= '0;
        dv_q[i][0].num <= {gmag[i][VALUE_W:0], {FRAC_BITS{1'b0}}};
        neg_q[i][0]    <= g2[i][LERP_W-1];
      end
      for (int s = 1; s <= DIV_W; s++) begin
        val_q[s] <= val_q[s-1];
        for (int i = 0; i < 3; i++) begin
          dv_q[i][s]  <= div_step(dv_q[i][s-1], dsz[i]);
          neg_q[i][s] <= neg_q[i][s-1];
        end
      end
    end
  end

  // sign, saturation and output register
  logic signed [DIV_W:0]      q [3];
  logic signed [VALUE_W-1:0]  qs [3];
  logic [2:0]                 ovf;
  localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = neg_q[i][DIV_W] ? -$signed({1'b0, dv_q[i][DIV_W].num})
                             :  $signed({1'b0, dv_q[i][DIV_W].num});
      ovf[i] = !((&q[i][DIV_W:VALUE_W-1]) || !(|q[i][DIV_W:VALUE_W-1]));
      qs[i] = ovf[i] ? (q[i][DIV_W] ? VMIN : VMAX) : q[i][VALUE_W-1:0];
    end
  end

  result_t res_q;
  assign out_data_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vd_q[DIV_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.interp_value <= val_q[DIV_W];
      res_q.grad_x       <= qs[0];
      res_q.grad_y       <= qs[1];
      res_q.grad_z       <= qs[2];
      res_q.overflow     <= |ovf;
    end
  end

  a_stall_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("pipeline advanced while output stalled");

  a_ovf_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      (out_data_o.grad_x == VMAX || out_data_o.grad_x == VMIN ||
       out_data_o.grad_y == VMAX || out_data_o.grad_y == VMIN ||
       out_data_o.grad_z == VMAX || out_data_o.grad_z == VMIN))
    else $error("overflow flagged without a saturated gradient");

  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_valid_q) && $past(out_stall_i) |-> $stable(res_q))
    else $error("result register changed under stall");

endmodule
